>>> design/s2mac_pkg.sv
// ----------------------------------------------------------------------------
// s2mac_pkg: shared types, constants and functions
// Round constants, initial hash values, sigma functions, FSM states.
// ----------------------------------------------------------------------------
package s2mac_pkg;

  localparam int unsigned BYTES_PER_ITEM = 8;
  localparam int unsigned LANE_BYTES = 8;
  localparam logic [3:0]  CNT_LIMIT =
    (BYTES_PER_ITEM < LANE_BYTES) ? 4'(BYTES_PER_ITEM) : 4'(LANE_BYTES);

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_ABSORB = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_COMPRESS,
    ST_FINAL
  } back_state_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] data;
    logic [3:0]  cnt;
  } qitem_t;

  localparam logic [63:0] K_TAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] IV_TAB [4][8] = '{
    '{64'hc1059ed8, 64'h367cd507, 64'h3070dd17, 64'hf70e5939,
      64'hffc00b31, 64'h68581511, 64'h64f98fa7, 64'hbefa4fa4},
    '{64'h6a09e667, 64'hbb67ae85, 64'h3c6ef372, 64'ha54ff53a,
      64'h510e527f, 64'h9b05688c, 64'h1f83d9ab, 64'h5be0cd19},
    '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
    '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179}
  };

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [63:0] ssig0(input logic [63:0] x, input logic wide);
    if (wide) return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    return {32'h0, ror32(x[31:0], 7) ^ ror32(x[31:0], 18) ^ (x[31:0] >> 3)};
  endfunction

  function automatic logic [63:0] ssig1(input logic [63:0] x, input logic wide);
    if (wide) return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
    return {32'h0, ror32(x[31:0], 17) ^ ror32(x[31:0], 19) ^ (x[31:0] >> 10)};
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x, input logic wide);
    if (wide) return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
    return {32'h0, ror32(x[31:0], 2) ^ ror32(x[31:0], 13) ^ ror32(x[31:0], 22)};
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x, input logic wide);
    if (wide) return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
    return {32'h0, ror32(x[31:0], 6) ^ ror32(x[31:0], 11) ^ ror32(x[31:0], 25)};
  endfunction

endpackage

>>> design/s2mac_front.sv
// ----------------------------------------------------------------------------
// s2mac_front: request intake
// Classifies each request, saturates its byte count, queues it (2 deep).
// ----------------------------------------------------------------------------
module s2mac_front import s2mac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_data,
  input  logic [3:0]  in_cnt,
  output logic        q_valid,
  output qitem_t      q_item,
  input  logic        q_pop
);

  qitem_t     mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  qitem_t     item;

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = mem_r[rptr_r];

  always_comb begin
    item.kind = in_kind;
    item.data = in_data;
    item.cnt  = (in_kind == REQ_ABSORB) ? ((in_cnt > CNT_LIMIT) ? CNT_LIMIT : in_cnt) : 4'd0;
    wptr_nxt  = push  ? ~wptr_r : wptr_r;
    rptr_nxt  = q_pop ? ~rptr_r : rptr_r;
    fill_nxt  = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> design/s2mac_back.sv
// ----------------------------------------------------------------------------
// s2mac_back: absorb and compress engine
// Writes bytes into the chunk buffer one per cycle, runs one round per cycle.
// ----------------------------------------------------------------------------
module s2mac_back import s2mac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_mode,
  input  logic        q_valid,
  input  qitem_t      q_item,
  output logic        q_pop,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [63:0] res_word [8]
);

  back_state_t state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [63:0] hash_r [8];
  logic [63:0] v_r [8];
  logic [63:0] win_r [16];
  logic [63:0] cbuf_r [16];
  logic [63:0] kw_r;
  logic [63:0] total_r;
  logic [63:0] data_r;
  logic [3:0]  cnt_r;
  logic [6:0]  t_r;
  logic        res_valid_r;
  logic [63:0] res_r [8];

  logic        wide;
  logic [63:0] m;
  logic [6:0]  off_mask, off, rounds;
  logic [3:0]  widx;
  logic [2:0]  lane;
  logic        chunk_end;
  logic [63:0] w, k, t1, t2, ch, maj;
  logic        out_free;

  assign wide      = mode_r[1];
  assign m         = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  assign off_mask  = wide ? 7'h7F : 7'h3F;
  assign rounds    = wide ? 7'd80 : 7'd64;
  assign off       = total_r[6:0] & off_mask;
  // big-endian byte placement, same in every mode: chunk byte 0 sits in bits
  // 63:56 of entry 0; a narrow word is one half of an entry, upper half first
  assign widx      = off[6:3];
  assign lane      = 3'd7 - off[2:0];
  assign chunk_end = (off == off_mask);
  assign out_free  = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res_word  = res_r;

  always_comb begin
    if (t_r[6:4] == 3'd0) begin
      if (wide) begin
        w = cbuf_r[t_r[3:0]];
      end else begin
        w = {32'h0, t_r[0] ? cbuf_r[{1'b0, t_r[3:1]}][31:0]
                           : cbuf_r[{1'b0, t_r[3:1]}][63:32]};
      end
    end else begin
      w = (win_r[0] + ssig0(win_r[1], wide) + win_r[9] + ssig1(win_r[14], wide)) & m;
    end
    k   = wide ? K_TAB[t_r] : {32'h0, K_TAB[t_r][63:32]};
    ch  = (v_r[4] & v_r[5]) ^ (v_r[6] & ~v_r[4] & m);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = (v_r[7] + kw_r + ch + bsig1(v_r[4], wide)) & m;
    t2  = (maj + bsig0(v_r[0], wide)) & m;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == REQ_ABSORB && q_item.cnt != 4'd0) state_nxt = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (chunk_end) state_nxt = ST_COMPRESS;
        else if (cnt_r == 4'd1) state_nxt = ST_IDLE;
      end
      ST_COMPRESS: begin
        if (t_r == rounds) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) state_nxt = (cnt_r != 4'd0) ? ST_ABSORB : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ABSORB) begin
      cbuf_r[widx][8*lane +: 8] <= data_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          data_r <= q_item.data;
          cnt_r  <= q_item.cnt;
        end
      end
      ST_ABSORB: begin
        data_r <= data_r >> 8;
        cnt_r  <= cnt_r - 4'd1;
        if (chunk_end) begin
          for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i] & m;
          t_r <= 7'd0;
        end
      end
      ST_COMPRESS: begin
        t_r <= t_r + 7'd1;
        if (t_r < rounds) begin
          for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
          win_r[15] <= w;
          kw_r      <= (k + w) & m;
        end
        if (t_r != 7'd0) begin
          for (int i = 1; i < 8; i++) v_r[i] <= v_r[i-1];
          v_r[4] <= (v_r[3] + t1) & m;
          v_r[0] <= (t1 + t2) & m;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 2'd1;
      total_r     <= 64'd0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) hash_r[i] <= IV_TAB[1][i];
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_mode;
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      if (state_r == ST_IDLE && q_valid && q_item.kind == REQ_START) begin
        total_r <= 64'd0;
        for (int i = 0; i < 8; i++) hash_r[i] <= IV_TAB[mode_r][i];
      end
      if (state_r == ST_ABSORB) total_r <= total_r + 64'd1;
      if (state_r == ST_FINAL && out_free) begin
        res_valid_r <= 1'b1;
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= (hash_r[i] + v_r[i]) & m;
          res_r[i]  <= (hash_r[i] + v_r[i]) & m;
        end
      end
    end
  end

endmodule

>>> design/sha2_message_absorb_and_compress_top.sv
// ----------------------------------------------------------------------------
// sha2_message_absorb_and_compress_top: SHA-224/256/384/512 chunk engine
// Collects message bytes into chunks and emits hash words per chunk.
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_*    | in  | tuser: req_type; tdata: data_bytes[63:0], byte_count[67:64]
// out_*   | out | tdata: hash_word_0 .. hash_word_7, 64 bits each, word 0 lowest
// cfg_*   | in  | hash_mode, written when cfg_we is high
// Each request is popped from the queue, then its bytes are absorbed one per cycle;
// a full chunk then runs 64 or 80 rounds at one round per cycle.
// Synchronous active-low reset restores SHA-256 initial values and mode 1.
// A two-entry queue holds up to two requests while the engine or output stalls.
module sha2_message_absorb_and_compress_top import s2mac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // data_bytes[63:0], byte_count[67:64]
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [511:0] out_tdata,  // hash_word_0 .. hash_word_7
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata
);

  logic        q_valid, q_pop;
  qitem_t      q_item;
  logic [63:0] res_word [8];

  s2mac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_data  (in_tdata[63:0]),
    .in_cnt   (in_tdata[67:64]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  s2mac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_mode  (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_word  (res_word)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) out_tdata[64*i +: 64] = res_word[i];
  end

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid) else $error("queue full but empty");

  a_no_result_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !$rose(out_tvalid)) else $error("result right after request pop");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: SHA-2 message absorb and compress testbench
// Streams start and absorb requests in all four hash modes, predicts every
// chunk digest with an internal compression model and checks each output.
// ----------------------------------------------------------------------------
module tb;
  import s2mac_pkg::*;

  localparam logic [1:0] MODE_224 = 2'd0;
  localparam logic [1:0] MODE_256 = 2'd1;
  localparam logic [1:0] MODE_384 = 2'd2;
  localparam logic [1:0] MODE_512 = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         DRAIN_CYCLES = 200;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [511:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_wdata = '0;

  sha2_message_absorb_and_compress_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [1:0]   mode_q = MODE_256;
  logic [7:0]   chunk_mem [128];
  logic [63:0]  hash_q [8];
  logic [63:0]  byte_total;
  logic [511:0] digest_q [$];
  int           errors = 0;
  int           items_sent = 0;
  int           digests_seen = 0;
  int           cycles = 0;

  function automatic logic [63:0] rotr(logic [63:0] x, int n, bit wide);
    if (wide) return (x >> n) | (x << (64 - n));
    return {32'h0, (x[31:0] >> n) | (x[31:0] << (32 - n))};
  endfunction

  function automatic logic [63:0] iv_word(logic [1:0] md, int i);
    logic [63:0] v256 [8] = '{64'h6a09e667, 64'hbb67ae85, 64'h3c6ef372, 64'ha54ff53a,
      64'h510e527f, 64'h9b05688c, 64'h1f83d9ab, 64'h5be0cd19};
    logic [63:0] v224 [8] = '{64'hc1059ed8, 64'h367cd507, 64'h3070dd17, 64'hf70e5939,
      64'hffc00b31, 64'h68581511, 64'h64f98fa7, 64'hbefa4fa4};
    logic [63:0] v384 [8] = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507,
      64'h9159015a3070dd17, 64'h152fecd8f70e5939, 64'h67332667ffc00b31,
      64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
    logic [63:0] v512 [8] = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1, 64'h510e527fade682d1,
      64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    case (md)
      MODE_224: return v224[i];
      MODE_256: return v256[i];
      MODE_384: return v384[i];
      default:  return v512[i];
    endcase
  endfunction

  task automatic load_iv();
    for (int i = 0; i < 8; i++) hash_q[i] = iv_word(mode_q, i);
    byte_total = '0;
  endtask

  task automatic compress_chunk();
    bit          wide;
    int          wb, rounds;
    logic [63:0] m, w, k, ch, maj, t1, t2, x15, x2;
    logic [63:0] v [8];
    logic [63:0] win [16];
    wide = mode_q >= MODE_384;
    wb = wide ? 8 : 4;
    rounds = wide ? 80 : 64;
    m = wide ? '1 : 64'hffffffff;
    for (int i = 0; i < 8; i++) v[i] = hash_q[i] & m;
    for (int t = 0; t < rounds; t++) begin
      if (t < 16) begin
        w = '0;
        for (int i = 0; i < wb; i++) w = (w << 8) | 64'(chunk_mem[7'(t * wb + i)]);
      end else begin
        x15 = win[4'(t - 15)];
        x2 = win[4'(t - 2)];
        w = win[4'(t)] + win[4'(t - 7)];
        w += wide ? (rotr(x15, 1, 1) ^ rotr(x15, 8, 1) ^ (x15 >> 7))
                  : (rotr(x15, 7, 0) ^ rotr(x15, 18, 0) ^ ((x15 & m) >> 3));
        w += wide ? (rotr(x2, 19, 1) ^ rotr(x2, 61, 1) ^ (x2 >> 6))
                  : (rotr(x2, 17, 0) ^ rotr(x2, 19, 0) ^ ((x2 & m) >> 10));
      end
      w &= m;
      win[4'(t)] = w;
      k = wide ? K_TAB[t] : (K_TAB[t] >> 32);
      ch = (v[4] & v[5]) ^ (v[6] & ~v[4]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + k + w + ch + (wide
        ? (rotr(v[4], 14, 1) ^ rotr(v[4], 18, 1) ^ rotr(v[4], 41, 1))
        : (rotr(v[4], 6, 0) ^ rotr(v[4], 11, 0) ^ rotr(v[4], 25, 0)));
      t2 = maj + (wide
        ? (rotr(v[0], 28, 1) ^ rotr(v[0], 34, 1) ^ rotr(v[0], 39, 1))
        : (rotr(v[0], 2, 0) ^ rotr(v[0], 13, 0) ^ rotr(v[0], 22, 0)));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = (v[4] + t1) & m;
      v[0] = (t1 + t2) & m;
    end
    for (int i = 0; i < 8; i++) hash_q[i] = (hash_q[i] + v[i]) & m;
  endtask

  task automatic predict_request(logic kind, logic [63:0] data, logic [3:0] cnt);
    int          n;
    logic [63:0] csize, off;
    logic [511:0] dig;
    if (kind == REQ_START) begin
      load_iv();
      return;
    end
    n = (cnt > CNT_LIMIT) ? int'(CNT_LIMIT) : int'(cnt);
    csize = (mode_q >= MODE_384) ? 64'd128 : 64'd64;
    for (int i = 0; i < n; i++) begin
      off = byte_total % csize;
      chunk_mem[off[6:0]] = data[8*i +: 8];
      byte_total++;
      if (off == csize - 64'd1) begin
        compress_chunk();
        for (int j = 0; j < 8; j++) dig[64*j +: 64] = hash_q[j];
        digest_q.push_back(dig);
      end
    end
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send_request(logic kind, logic [63:0] data, logic [3:0] cnt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'h0, cnt, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(kind, data, cnt);
    items_sent++;
  endtask

  // receiver: stall pattern that changes phase now and then
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= (cycles % 5) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [511:0] exp_dig;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest with no request pending: %h", out_tdata);
        errors++;
      end else begin
        exp_dig = digest_q.pop_front();
        for (int j = 0; j < 8; j++)
          if (exp_dig[64*j +: 64] !== out_tdata[64*j +: 64]) begin
            $error("hash_word_%0d expected %h actual %h", j, exp_dig[64*j +: 64],
                   out_tdata[64*j +: 64]);
            errors++;
          end
      end
      digests_seen++;
    end
  end

  // drop the request line, hold until every digest is out and the engine is quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] md);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= md;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = md;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    // default mode after reset, one exact chunk of all-ones then all-zero bytes
    for (int i = 0; i < 4; i++) send_request(REQ_ABSORB, '1, 4'd8);
    for (int i = 0; i < 4; i++) send_request(REQ_ABSORB, '0, 4'd8);
    send_request(REQ_START, rand64(), 4'hf);
    // oversized counts saturate; zero count adds nothing
    send_request(REQ_ABSORB, rand64(), 4'hf);
    send_request(REQ_ABSORB, rand64(), 4'd0);
    for (int i = 0; i < 7; i++) send_request(REQ_ABSORB, rand64(), 4'd9);
    // the requests before end on a chunk boundary; this one starts a new chunk
    send_request(REQ_ABSORB, rand64(), 4'd3);
    send_request(REQ_ABSORB, 64'h0123456789abcdef, 4'd8);
  endtask

  task automatic test_mode(logic [1:0] md, int n_items);
    set_mode(md);
    send_request(REQ_START, rand64(), 4'($urandom_range(0, 15)));
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 19))
        0: send_request(REQ_START, rand64(), 4'($urandom_range(0, 15)));
        1: send_request(REQ_ABSORB, rand64(), 4'($urandom_range(9, 15)));
        2, 3: send_request(REQ_ABSORB, rand64(), 4'($urandom_range(0, 7)));
        default: send_request(REQ_ABSORB, rand64(), 4'd8);
      endcase
    end
  endtask

  // switch mode mid-message without a start
  task automatic test_mode_switch();
    set_mode(MODE_512);
    send_request(REQ_START, '0, 4'd0);
    for (int i = 0; i < 10; i++) send_request(REQ_ABSORB, rand64(), 4'd8);
    set_mode(MODE_224);
    for (int i = 0; i < 10; i++) send_request(REQ_ABSORB, rand64(), 4'($urandom_range(5, 8)));
    set_mode(MODE_384);
    for (int i = 0; i < 20; i++) send_request(REQ_ABSORB, rand64(), 4'd8);
  endtask

  initial begin
    load_iv();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_mode(MODE_224, 80);
    test_mode(MODE_256, 80);
    test_mode(MODE_384, 90);
    test_mode(MODE_512, 90);
    test_mode_switch();
    wait_idle();
    $display("sent %0d requests over all four hash modes, checked %0d digests",
             items_sent, digests_seen);
    $display("covered saturated counts, split chunk boundaries and mid-message mode changes");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
